FILE: sv/rvex_pkg.sv
// Package for the RV32IM execute block: constants, opcodes, and the
// controller/datapath command, status and result types. No dependencies.
package rvex_pkg;

  localparam int unsigned DMEM_BYTES = 65536;  // must be a power of two
  localparam int unsigned DMEM_AW    = $clog2(DMEM_BYTES);
  localparam int unsigned NREGS      = 32;
  localparam int unsigned RF_AW      = $clog2(NREGS);

  localparam logic [31:0] RESET_PC      = 32'h8000_0000;
  localparam logic [31:0] MSTATUS_RESET = 32'd6144;
  localparam logic [31:0] CAUSE_ECALL   = 32'd11;

  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;
  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MTVEC   = 12'h305;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [31:0] INSTR_MRET   = 32'h3020_0073;
  localparam logic [31:0] INSTR_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;

  localparam logic [RF_AW-1:0] REG_A0 = RF_AW'(10);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EBREAK  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_BADCSR  = 2'd3;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_MEM,
    CLS_MUL,
    CLS_DIV
  } rvex_cls_e;

  typedef struct packed {
    logic accept;
    logic load_ops;
    logic exec;
    logic mem_step;
    logic mul_fin;
    logic div_fin;
    logic commit;
  } rvex_cmd_t;

  typedef struct packed {
    rvex_cls_e cls;
    logic      mem_last;
    logic      div_done;
  } rvex_sts_t;

  typedef struct packed {
    logic [31:0]      executed_pc;
    logic [31:0]      next_pc;
    logic             register_written;
    logic [RF_AW-1:0] dest_register;
    logic [31:0]      dest_value;
    logic [1:0]       status;
    logic [31:0]      halt_code;
  } rvex_res_t;

endpackage

FILE: sv/rvex_if.sv
// Handshake channel interfaces for the RV32IM execute block.
// No dependencies.
interface rvex_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface rvex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] executed_pc;
  logic [31:0] next_pc;
  logic        register_written;
  logic [4:0]  dest_register;
  logic [31:0] dest_value;
  logic [1:0]  status;
  logic [31:0] halt_code;
  modport source (output valid, output executed_pc, output next_pc,
                  output register_written, output dest_register, output dest_value,
                  output status, output halt_code, input ready);
  modport sink (input valid, input executed_pc, input next_pc,
                input register_written, input dest_register, input dest_value,
                input status, input halt_code, output ready);
endinterface

interface rvex_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] reset_pc;
  modport source (output valid, output reset_pc, input ready);
  modport sink (input valid, input reset_pc, output ready);
endinterface

FILE: sv/rvex_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvex_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/rvex_div.sv
// Iterative restoring divider, one quotient bit per cycle, with RISC-V
// sign and divide-by-zero handling. Depends on nothing but plain logic.
module rvex_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        signed_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, ub_q, ub_d, orig_q, orig_d;
  logic        negq_q, negq_d, negr_q, negr_d, zero_q, zero_d;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        take;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ub_d   = ub_q;
    orig_d = orig_q;
    negq_d = negq_q;
    negr_d = negr_q;
    zero_d = zero_q;
    rem_sh = {rem_q, quo_q[31]};
    diff   = {1'b0, rem_sh} - {2'b00, ub_q};
    take   = ~diff[33];
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      orig_d = dividend_i;
      quo_d  = (signed_i && dividend_i[31]) ? (32'd0 - dividend_i) : dividend_i;
      ub_d   = (signed_i && divisor_i[31]) ? (32'd0 - divisor_i) : divisor_i;
      negq_d = signed_i && (dividend_i[31] ^ divisor_i[31]);
      negr_d = signed_i && dividend_i[31];
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      rem_d = take ? diff[31:0] : rem_sh[31:0];
      quo_d = {quo_q[30:0], take};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ub_q   <= ub_d;
    orig_q <= orig_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '1 : (negq_q ? (32'd0 - quo_q) : quo_q);
  assign rem_o  = zero_q ? orig_q : (negr_q ? (32'd0 - rem_q) : rem_q);

endmodule

FILE: sv/rvex_ctrl.sv
// Sequencing state machine of the RV32IM execute block.
// Depends on rvex_pkg for the command and status types.
module rvex_ctrl
  import rvex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rvex_sts_t sts_i,
  output rvex_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       outv_q, outv_d;
  logic       slot_free;

  assign slot_free = !outv_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.load_ops = (state_q == S_READ);
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.mem_step = (state_q == S_MEM);
    cmd_o.mul_fin  = (state_q == S_MUL);
    cmd_o.div_fin  = (state_q == S_DIV) && sts_i.div_done;
    cmd_o.commit   = (state_q == S_DONE) && slot_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        case (sts_i.cls)
          CLS_MEM: state_d = S_MEM;
          CLS_MUL: state_d = S_MUL;
          CLS_DIV: state_d = S_DIV;
          default: state_d = S_DONE;
        endcase
      end
      S_MEM:  if (sts_i.mem_last) state_d = S_DONE;
      S_MUL:  state_d = S_DONE;
      S_DIV:  if (sts_i.div_done) state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    outv_d = outv_q;
    if (cmd_o.commit) begin
      outv_d = 1'b1;
    end else if (out_ready_i) begin
      outv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = outv_q;

endmodule

FILE: sv/rvex_dpath.sv
// Datapath of the RV32IM execute block: register file, decode and ALU,
// multiplier, divider, data memory, CSRs and result register.
// Depends on rvex_pkg, rvex_ram and rvex_div.
module rvex_dpath
  import rvex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] instr_i,
  input  rvex_cmd_t   cmd_i,
  output rvex_sts_t   sts_o,
  output rvex_res_t   res_o
);

  logic [31:0] instr_q, pc_q, a_q, b_q, res_q, next_q, halt_q;
  logic        wr_q;
  logic [1:0]  status_q;
  logic [31:0] mepc_q, mcause_q, mstatus_q, mtvec_q;
  logic [31:0] mepc_n_q, mcause_n_q, mstatus_n_q, mtvec_n_q;
  logic        store_q;
  logic [2:0]  mem_n_q, cnt_q;
  logic [DMEM_AW-1:0] base_q;
  logic [31:0] ld_q;
  logic signed [65:0] prod_q;
  logic [NREGS-1:0] rf_vld_q;
  rvex_res_t   out_q;

  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [RF_AW-1:0] rd, rs1, rs2b, rs2b_in;
  logic [31:0] immi, imms, immb, immj;
  logic [31:0] rda, rdb;
  logic [31:0] ex_val, ex_next, ex_halt, n_mepc, n_mcause, n_mstatus, n_mtvec;
  logic [31:0] csr_old, csr_new, opb;
  logic        ex_wr, ex_store, take, csr_hit;
  logic [1:0]  ex_st;
  rvex_cls_e   ex_cls;
  logic [2:0]  ex_n;
  logic [4:0]  sh;
  logic signed [32:0] ma, mb;
  logic        div_done;
  logic [31:0] div_q, div_r;
  logic [DMEM_AW-1:0] mem_addr;
  logic [7:0]  mem_rdata;
  logic [1:0]  ld_idx;
  logic [31:0] ld_ext, fin_val;
  logic        fin_wr;

  assign opc  = instr_q[6:0];
  assign f3   = instr_q[14:12];
  assign f7   = instr_q[31:25];
  assign rd   = instr_q[11:7];
  assign rs1  = instr_q[19:15];
  assign immi = {{20{instr_q[31]}}, instr_q[31:20]};
  assign imms = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
  assign immb = {{20{instr_q[31]}}, instr_q[7], instr_q[30:25], instr_q[11:8], 1'b0};
  assign immj = {{12{instr_q[31]}}, instr_q[19:12], instr_q[20], instr_q[30:21], 1'b0};

  // Port B reads a0 for ebreak so the halt code comes from the same read.
  assign rs2b_in = (instr_i == INSTR_EBREAK) ? REG_A0 : instr_i[24:20];
  assign rs2b    = (instr_q == INSTR_EBREAK) ? REG_A0 : instr_q[24:20];

  assign fin_wr  = wr_q && (rd != '0);
  assign fin_val = (opc == OPC_LOAD) ? ld_ext : res_q;

  rvex_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_a (
    .clk_i, .we_i(cmd_i.commit && fin_wr), .waddr_i(rd), .wdata_i(fin_val),
    .raddr_i(instr_i[19:15]), .rdata_o(rda)
  );

  rvex_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_b (
    .clk_i, .we_i(cmd_i.commit && fin_wr), .waddr_i(rd), .wdata_i(fin_val),
    .raddr_i(rs2b_in), .rdata_o(rdb)
  );

  assign mem_addr = base_q + DMEM_AW'(cnt_q);

  rvex_ram #(.WIDTH(8), .DEPTH(DMEM_BYTES)) u_dmem (
    .clk_i, .we_i(cmd_i.mem_step && store_q), .waddr_i(mem_addr),
    .wdata_i(b_q[8*cnt_q[1:0] +: 8]), .raddr_i(mem_addr), .rdata_o(mem_rdata)
  );

  rvex_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.exec && (ex_cls == CLS_DIV)),
    .signed_i(!f3[0]),
    .dividend_i(a_q),
    .divisor_i(b_q),
    .done_o(div_done),
    .quot_o(div_q),
    .rem_o(div_r)
  );

  always_comb begin
    ex_val    = '0;
    ex_next   = pc_q + 32'd4;
    ex_wr     = 1'b0;
    ex_st     = ST_OK;
    ex_cls    = CLS_PLAIN;
    ex_store  = 1'b0;
    ex_halt   = '0;
    n_mepc    = mepc_q;
    n_mcause  = mcause_q;
    n_mstatus = mstatus_q;
    n_mtvec   = mtvec_q;
    take      = 1'b0;
    csr_hit   = 1'b1;
    csr_old   = '0;
    opb       = (opc == OPC_OPIMM) ? immi : b_q;
    sh        = opb[4:0];
    case (opc)
      OPC_LUI: begin
        ex_wr  = 1'b1;
        ex_val = {instr_q[31:12], 12'b0};
      end
      OPC_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc_q + {instr_q[31:12], 12'b0};
      end
      OPC_JAL: begin
        ex_wr   = 1'b1;
        ex_val  = pc_q + 32'd4;
        ex_next = pc_q + immj;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) begin
          ex_st = ST_INVALID;
        end else begin
          ex_wr   = 1'b1;
          ex_val  = pc_q + 32'd4;
          ex_next = (a_q + immi) & ~32'd1;
        end
      end
      OPC_LOAD: begin
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
          ex_st = ST_INVALID;
        end else begin
          ex_wr  = 1'b1;
          ex_cls = CLS_MEM;
        end
      end
      OPC_STORE: begin
        if (f3 > 3'd2) begin
          ex_st = ST_INVALID;
        end else begin
          ex_cls   = CLS_MEM;
          ex_store = 1'b1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: take = (a_q == b_q);
          3'd1: take = (a_q != b_q);
          3'd4: take = ($signed(a_q) < $signed(b_q));
          3'd5: take = ($signed(a_q) >= $signed(b_q));
          3'd6: take = (a_q < b_q);
          3'd7: take = (a_q >= b_q);
          default: ex_st = ST_INVALID;
        endcase
        if (take) ex_next = pc_q + immb;
      end
      OPC_OPIMM, OPC_OP: begin
        ex_wr = 1'b1;
        if (opc == OPC_OP && f7 == F7_MULDIV) begin
          case (f3)
            3'd0, 3'd1, 3'd3: ex_cls = CLS_MUL;
            3'd2: begin
              ex_wr = 1'b0;
              ex_st = ST_INVALID;
            end
            default: ex_cls = CLS_DIV;
          endcase
        end else if (opc == OPC_OP && f7 != F7_BASE &&
                     !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
          ex_wr = 1'b0;
          ex_st = ST_INVALID;
        end else if (opc == OPC_OPIMM && f3 == 3'd1 && f7 != F7_BASE) begin
          ex_wr = 1'b0;
          ex_st = ST_INVALID;
        end else if (opc == OPC_OPIMM && f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT) begin
          ex_wr = 1'b0;
          ex_st = ST_INVALID;
        end else begin
          case (f3)
            3'd0: ex_val = (opc == OPC_OP && f7 == F7_ALT) ? (a_q - opb) : (a_q + opb);
            3'd1: ex_val = a_q << sh;
            3'd2: ex_val = {31'd0, $signed(a_q) < $signed(opb)};
            3'd3: ex_val = {31'd0, a_q < opb};
            3'd4: ex_val = a_q ^ opb;
            3'd5: ex_val = (f7 == F7_ALT) ? 32'($signed(a_q) >>> sh) : (a_q >> sh);
            3'd6: ex_val = a_q | opb;
            default: ex_val = a_q & opb;
          endcase
        end
      end
      OPC_SYSTEM: begin
        if (f3 == 3'd1 || f3 == 3'd2) begin
          case (instr_q[31:20])
            CSR_MEPC:    csr_old = mepc_q;
            CSR_MCAUSE:  csr_old = mcause_q;
            CSR_MSTATUS: csr_old = mstatus_q;
            CSR_MTVEC:   csr_old = mtvec_q;
            default:     csr_hit = 1'b0;
          endcase
          if (!csr_hit) begin
            ex_st = ST_BADCSR;
          end else begin
            ex_wr  = 1'b1;
            ex_val = csr_old;
          end
        end else if (instr_q == INSTR_MRET) begin
          n_mstatus        = mstatus_q;
          n_mstatus[3]     = mstatus_q[7];
          n_mstatus[7]     = 1'b1;
          n_mstatus[12:11] = 2'b00;
          ex_next          = mepc_q;
        end else if (instr_q == INSTR_ECALL) begin
          n_mepc   = pc_q + 32'd4;
          n_mcause = CAUSE_ECALL;
          ex_next  = mtvec_q;
        end else if (instr_q == INSTR_EBREAK) begin
          ex_st   = ST_EBREAK;
          ex_halt = b_q;
        end else begin
          ex_st = ST_INVALID;
        end
      end
      default: ex_st = ST_INVALID;
    endcase
    csr_new = (f3 == 3'd1) ? a_q : (csr_old | a_q);
    if (opc == OPC_SYSTEM && csr_hit && (f3 == 3'd1 || f3 == 3'd2)) begin
      case (instr_q[31:20])
        CSR_MEPC:    n_mepc = csr_new;
        CSR_MCAUSE:  n_mcause = csr_new;
        CSR_MSTATUS: n_mstatus = csr_new;
        default:     n_mtvec = csr_new;
      endcase
    end
  end

  always_comb begin
    case (f3[1:0])
      2'd0:    ex_n = 3'd1;
      2'd1:    ex_n = 3'd2;
      default: ex_n = 3'd4;
    endcase
    ma = (f3 == 3'd3) ? $signed({1'b0, a_q}) : $signed({a_q[31], a_q});
    mb = (f3 == 3'd3) ? $signed({1'b0, b_q}) : $signed({b_q[31], b_q});
    case (f3)
      3'd0:    ld_ext = {{24{ld_q[7]}}, ld_q[7:0]};
      3'd1:    ld_ext = {{16{ld_q[15]}}, ld_q[15:0]};
      3'd4:    ld_ext = {24'd0, ld_q[7:0]};
      3'd5:    ld_ext = {16'd0, ld_q[15:0]};
      default: ld_ext = ld_q;
    endcase
  end

  assign ld_idx = cnt_q[1:0] - 2'd1;

  assign sts_o.cls      = ex_cls;
  assign sts_o.mem_last = store_q ? (cnt_q == mem_n_q - 3'd1) : (cnt_q == mem_n_q);
  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= RESET_PC;
      mepc_q    <= '0;
      mcause_q  <= '0;
      mstatus_q <= MSTATUS_RESET;
      mtvec_q   <= '0;
      rf_vld_q  <= '0;
    end else if (cmd_i.commit) begin
      pc_q      <= next_q;
      mepc_q    <= mepc_n_q;
      mcause_q  <= mcause_n_q;
      mstatus_q <= mstatus_n_q;
      mtvec_q   <= mtvec_n_q;
      if (fin_wr) rf_vld_q[rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) instr_q <= instr_i;
    if (cmd_i.load_ops) begin
      a_q <= rf_vld_q[rs1] ? rda : '0;
      b_q <= rf_vld_q[rs2b] ? rdb : '0;
    end
    if (cmd_i.exec) begin
      res_q       <= ex_val;
      next_q      <= ex_next;
      wr_q        <= ex_wr;
      status_q    <= ex_st;
      halt_q      <= ex_halt;
      mepc_n_q    <= n_mepc;
      mcause_n_q  <= n_mcause;
      mstatus_n_q <= n_mstatus;
      mtvec_n_q   <= n_mtvec;
      store_q     <= ex_store;
      mem_n_q     <= ex_n;
      cnt_q       <= '0;
      base_q      <= DMEM_AW'(a_q + (ex_store ? imms : immi));
      prod_q      <= ma * mb;
    end
    if (cmd_i.mem_step) begin
      cnt_q <= cnt_q + 3'd1;
      if (!store_q && cnt_q != 3'd0) ld_q[8*ld_idx +: 8] <= mem_rdata;
    end
    if (cmd_i.mul_fin) res_q <= (f3 == 3'd0) ? prod_q[31:0] : prod_q[63:32];
    if (cmd_i.div_fin) res_q <= f3[1] ? div_r : div_q;
    if (cmd_i.commit) begin
      out_q.executed_pc      <= pc_q;
      out_q.next_pc          <= next_q;
      out_q.register_written <= fin_wr;
      out_q.dest_register    <= fin_wr ? rd : '0;
      out_q.dest_value       <= fin_wr ? fin_val : '0;
      out_q.status           <= status_q;
      out_q.halt_code        <= halt_q;
    end
  end

  assign res_o = out_q;

endmodule

FILE: sv/rv32im_instruction_execute.sv
// Top level of the RV32IM execute block: channel interfaces, controller
// and datapath. Depends on rvex_pkg, rvex_if, rvex_ctrl and rvex_dpath.
//
// Usage: the in_i channel carries one instruction word per item, fetched by
// the user at the pc reported as next_pc of the previous result (the first
// pc after reset is 0x8000_0000). Every item yields exactly one result item
// on out_o. cfg_i takes the reset_pc register; it is always ready. The
// register is restored to its default by reset; the program counter is
// reset to a constant and never loaded from it, so a write has no visible effect.
// Sequencing: one item at a time. An item passes register read, execute and
// writeback; multiplies add a multiply step, loads and stores step through
// the data memory one byte at a time (the data memory has a single byte-wide
// port), and divides wait for the divider, which resolves one quotient bit
// per cycle.
// Reset clears the register file valid bits, mepc, mcause and mtvec, presets
// mstatus and the pc; the data memory is not cleared and must be written before it is read.
// Stalls: the result waits in an output register. The next item is taken
// while it waits, and only the writeback of that next item waits for out_o.
module rv32im_instruction_execute
  import rvex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rvex_in_if.sink     in_i,
  rvex_out_if.source  out_o,
  rvex_cfg_if.sink    cfg_i
);

  rvex_cmd_t   cmd;
  rvex_sts_t   sts;
  rvex_res_t   res;
  logic [31:0] reset_pc_q;

  // Holds the configured value; no logic of the block uses it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_pc_q <= RESET_PC;
    end else if (cfg_i.valid) begin
      reset_pc_q <= cfg_i.reset_pc;
    end
  end

  assign cfg_i.ready = 1'b1;

  rvex_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rvex_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .instr_i(in_i.instruction),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign out_o.executed_pc      = res.executed_pc;
  assign out_o.next_pc          = res.next_pc;
  assign out_o.register_written = res.register_written;
  assign out_o.dest_register    = res.dest_register;
  assign out_o.dest_value       = res.dest_value;
  assign out_o.status           = res.status;
  assign out_o.halt_code        = res.halt_code;

  // Writeback must never overwrite a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("result overwritten before it was taken");

  // Writeback presents a result in the following cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("committed result not presented");

  // Only one item is in flight: after acceptance the input closes.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item accepted while busy");

  // A result without a register write carries no destination.
  a_no_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.register_written) |->
      (out_o.dest_register == '0 && out_o.dest_value == '0))
    else $error("destination reported without a write");

  // The configured value follows accepted writes.
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready) |=> (reset_pc_q == $past(cfg_i.reset_pc)))
    else $error("reset_pc write lost");

endmodule
